/* rtl/sv39ptm_pkg.sv */
package sv39ptm_pkg;

  // Number of 512-entry tables in the pool; table 0 is the root.
  localparam int unsigned TABLE_POOL    = 64;

  localparam int unsigned IDX_W         = 9;
  localparam int unsigned TABLE_ENTRIES = 1 << IDX_W;
  localparam int unsigned VPN_W         = 3 * IDX_W;
  localparam int unsigned PPN_W         = 44;
  localparam int unsigned FLAG_W        = 10;
  localparam int unsigned ENTRY_W       = PPN_W + FLAG_W;

  localparam int unsigned TAB_W         = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int unsigned NFT_W         = $clog2(TABLE_POOL + 1);
  localparam int unsigned MEM_DEPTH     = TABLE_POOL * TABLE_ENTRIES;
  localparam int unsigned ADDR_W        = TAB_W + IDX_W;

  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned S_TDATA_W     = ((VPN_W + PPN_W + FLAG_W + 1 + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W     = ((PPN_W + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W     = STATUS_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED    = 2'd0,
    ST_UNMAPPED  = 2'd1,
    ST_NOTHING   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_UNMAP = 1'b1
  } op_e;

endpackage

/* rtl/sv39ptm_ram.sv */
module sv39ptm_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port; read data is registered and shows up in the cycle after the read request.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sv39_page_table_mapper.sv */
// Sv39 page table mapper. Each input request maps or unmaps one 4 KiB page in a pool of
// TABLE_POOL three-level page tables held in one single-port table memory, and gives
// exactly one result. A map walks from the root table, takes a fresh table from a bump
// allocator wherever an upper entry is invalid (checking up front that enough tables
// remain), clears it, links it and writes the leaf with its valid bit forced on. An unmap
// walks without allocating, clears a valid leaf and reports its frame. The single memory
// port sets the rate, so requests are handled one at a time; every newly allocated table
// adds a clearing write to each of its 512 entries plus the link write, and after
// allocation the leaf gets a write of its own. After reset the whole table memory is
// cleared, all TABLE_POOL * 512 entries (32768 for the default pool), during which
// s_axis_tready stays low; configuration writes are taken at any time. The result sits in
// an output register, so the next request is accepted while a result waits to be taken.
module sv39_page_table_mapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: pool_base_page.
  input  logic                              cfg_wr_en_i,
  input  logic [sv39ptm_pkg::PPN_W-1:0]     cfg_wr_data_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: virt_page[26:0], phys_page[70:27], pte_flags[80:71],
  // release_req[81], zero padding.
  input  logic [sv39ptm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Field: operation.
  input  logic                              s_axis_tuser,
  // range_end.
  input  logic                              s_axis_tlast,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: released_page[43:0], zero padding.
  output logic [sv39ptm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: status[1:0], release_valid[2].
  output logic [sv39ptm_pkg::M_TUSER_W-1:0] m_axis_tuser,
  // range_done.
  output logic                              m_axis_tlast
);

  import sv39ptm_pkg::*;

  // Bit positions of the request fields inside s_axis_tdata.
  localparam int unsigned VPN_LSB  = 0;
  localparam int unsigned PPN_LSB  = VPN_LSB + VPN_W;
  localparam int unsigned FLAG_LSB = PPN_LSB + PPN_W;
  localparam int unsigned FREE_BIT = FLAG_LSB + FLAG_W;

  typedef enum logic [3:0] {
    S_INIT,      // clearing the whole table memory after reset
    S_IDLE,      // waiting for a request; the root read is issued on acceptance
    S_WALK2,     // root entry on the read port
    S_WALK1,     // level-1 entry on the read port
    S_LEAF_RD,   // leaf entry on the read port (unmap)
    S_CLEAR,     // clearing a freshly allocated table, one entry per cycle
    S_LINK,      // writing the pointer to the new table into its parent
    S_LEAF_WR,   // writing the leaf after allocation
    S_DONE       // moving the result into the output register
  } state_e;

  state_e              state_q, state_d;
  logic [PPN_W-1:0]    base_q, base_d;
  logic [NFT_W-1:0]    nf_q, nf_d;
  logic [ADDR_W-1:0]   sweep_q, sweep_d;
  logic                lvl_q, lvl_d;      // 1 while allocating the level-1 table
  logic [TAB_W-1:0]    t1_q, t1_d;
  logic [TAB_W-1:0]    t0_q, t0_d;

  op_e                 op_q, op_d;
  logic [VPN_W-1:0]    vpn_q, vpn_d;
  logic [PPN_W-1:0]    ppn_q, ppn_d;
  logic [FLAG_W-1:0]   flags_q, flags_d;
  logic                free_q, free_d;
  logic                rend_q, rend_d;

  status_e             res_status_q, res_status_d;
  logic                res_rel_valid_q, res_rel_valid_d;
  logic [PPN_W-1:0]    res_rel_page_q, res_rel_page_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic                out_rel_valid_q, out_rel_valid_d;
  logic [PPN_W-1:0]    out_rel_page_q, out_rel_page_d;
  logic                out_last_q, out_last_d;

  // Table memory port.
  logic                ram_en;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [IDX_W-1:0]    idx2, idx1, idx0;
  logic [VPN_W-1:0]    s_vpn;
  logic                entry_valid;
  logic [PPN_W-1:0]    entry_ppn;
  logic [PPN_W-1:0]    rel;
  logic                rel_in_pool;
  logic [TAB_W-1:0]    rel_tab;
  logic [TAB_W-1:0]    nf_tab;
  logic [NFT_W:0]      nf_ext;
  logic                fits1, fits2;
  logic [ENTRY_W-1:0]  ptr_word;
  logic [ENTRY_W-1:0]  leaf_word;

  sv39ptm_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign s_vpn = s_axis_tdata[VPN_LSB +: VPN_W];
  assign idx2  = vpn_q[2*IDX_W +: IDX_W];
  assign idx1  = vpn_q[IDX_W +: IDX_W];
  assign idx0  = vpn_q[0 +: IDX_W];

  // An upper entry names table t when its page number minus the pool base, taken modulo
  // 2^44, is below the pool size.
  assign entry_valid = ram_rdata[0];
  assign entry_ppn   = ram_rdata[FLAG_W +: PPN_W];
  assign rel         = entry_ppn - base_q;
  assign rel_in_pool = (rel < PPN_W'(TABLE_POOL));
  assign rel_tab     = rel[TAB_W-1:0];

  // The allocator never hands out more than the pool holds, so the next free index is
  // a table index whenever an allocation is allowed.
  assign nf_tab = nf_q[TAB_W-1:0];
  assign nf_ext = {1'b0, nf_q};
  assign fits1  = (nf_ext + (NFT_W+1)'(1)) <= (NFT_W+1)'(TABLE_POOL);
  assign fits2  = (nf_ext + (NFT_W+1)'(2)) <= (NFT_W+1)'(TABLE_POOL);

  assign ptr_word  = {base_q + PPN_W'(nf_q), {(FLAG_W-1){1'b0}}, 1'b1};
  assign leaf_word = {ppn_q, flags_q | FLAG_W'(1)};

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    base_d          = base_q;
    nf_d            = nf_q;
    sweep_d         = sweep_q;
    lvl_d           = lvl_q;
    t1_d            = t1_q;
    t0_d            = t0_q;
    op_d            = op_q;
    vpn_d           = vpn_q;
    ppn_d           = ppn_q;
    flags_d         = flags_q;
    free_d          = free_q;
    rend_d          = rend_q;
    res_status_d    = res_status_q;
    res_rel_valid_d = res_rel_valid_q;
    res_rel_page_d  = res_rel_page_q;
    out_valid_d     = out_valid_q;
    out_status_d    = out_status_q;
    out_rel_valid_d = out_rel_valid_q;
    out_rel_page_d  = out_rel_page_q;
    out_last_d      = out_last_q;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = '0;

    if (cfg_wr_en_i) begin
      base_d = cfg_wr_data_i;
    end

    // The output register drains on its own handshake.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = sweep_q;
        if (sweep_q == ADDR_W'(MEM_DEPTH - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d            = op_e'(s_axis_tuser);
          vpn_d           = s_vpn;
          ppn_d           = s_axis_tdata[PPN_LSB +: PPN_W];
          flags_d         = s_axis_tdata[FLAG_LSB +: FLAG_W];
          free_d          = s_axis_tdata[FREE_BIT];
          rend_d          = s_axis_tlast;
          res_rel_valid_d = 1'b0;
          res_rel_page_d  = '0;
          ram_en          = 1'b1;
          ram_addr        = {TAB_W'(0), s_vpn[2*IDX_W +: IDX_W]};
          state_d         = S_WALK2;
        end
      end

      S_WALK2: begin
        if (entry_valid && rel_in_pool) begin
          t1_d     = rel_tab;
          ram_en   = 1'b1;
          ram_addr = {rel_tab, idx1};
          state_d  = S_WALK1;
        end else if (entry_valid) begin
          // Root entry points outside the pool.
          res_status_d = (op_q == OP_MAP) ? ST_EXHAUSTED : ST_NOTHING;
          state_d      = S_DONE;
        end else if (op_q == OP_UNMAP) begin
          res_status_d = ST_NOTHING;
          state_d      = S_DONE;
        end else if (fits2) begin
          lvl_d   = 1'b1;
          state_d = S_CLEAR;
        end else begin
          res_status_d = ST_EXHAUSTED;
          state_d      = S_DONE;
        end
      end

      S_WALK1: begin
        if (entry_valid && rel_in_pool) begin
          t0_d   = rel_tab;
          ram_en = 1'b1;
          if (op_q == OP_MAP) begin
            // Both levels exist: the leaf is written right away.
            ram_we       = 1'b1;
            ram_addr     = {rel_tab, idx0};
            ram_wdata    = leaf_word;
            res_status_d = ST_MAPPED;
            state_d      = S_DONE;
          end else begin
            ram_addr = {rel_tab, idx0};
            state_d  = S_LEAF_RD;
          end
        end else if (entry_valid) begin
          res_status_d = (op_q == OP_MAP) ? ST_EXHAUSTED : ST_NOTHING;
          state_d      = S_DONE;
        end else if (op_q == OP_UNMAP) begin
          res_status_d = ST_NOTHING;
          state_d      = S_DONE;
        end else if (fits1) begin
          lvl_d   = 1'b0;
          state_d = S_CLEAR;
        end else begin
          res_status_d = ST_EXHAUSTED;
          state_d      = S_DONE;
        end
      end

      S_LEAF_RD: begin
        if (entry_valid) begin
          ram_en          = 1'b1;
          ram_we          = 1'b1;
          ram_addr        = {t0_q, idx0};
          res_status_d    = ST_UNMAPPED;
          res_rel_valid_d = free_q;
          res_rel_page_d  = entry_ppn;
        end else begin
          res_status_d = ST_NOTHING;
        end
        state_d = S_DONE;
      end

      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = {nf_tab, sweep_q[IDX_W-1:0]};
        if (sweep_q[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1)) begin
          sweep_d = '0;
          state_d = S_LINK;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end

      S_LINK: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ptr_word;
        nf_d      = nf_q + NFT_W'(1);
        if (lvl_q) begin
          ram_addr = {TAB_W'(0), idx2};
          t1_d     = nf_tab;
          lvl_d    = 1'b0;
          state_d  = S_CLEAR;
        end else begin
          ram_addr = {t1_q, idx1};
          t0_d     = nf_tab;
          state_d  = S_LEAF_WR;
        end
      end

      S_LEAF_WR: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = {t0_q, idx0};
        ram_wdata    = leaf_word;
        res_status_d = ST_MAPPED;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d     = 1'b1;
          out_status_d    = res_status_q;
          out_rel_valid_d = res_rel_valid_q;
          out_rel_page_d  = res_rel_page_q;
          out_last_d      = rend_q;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_INIT;
      base_q          <= '0;
      nf_q            <= NFT_W'(1);
      sweep_q         <= '0;
      lvl_q           <= 1'b0;
      t1_q            <= '0;
      t0_q            <= '0;
      op_q            <= OP_MAP;
      vpn_q           <= '0;
      ppn_q           <= '0;
      flags_q         <= '0;
      free_q          <= 1'b0;
      rend_q          <= 1'b0;
      res_status_q    <= ST_MAPPED;
      res_rel_valid_q <= 1'b0;
      res_rel_page_q  <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= ST_MAPPED;
      out_rel_valid_q <= 1'b0;
      out_rel_page_q  <= '0;
      out_last_q      <= 1'b0;
    end else begin
      state_q         <= state_d;
      base_q          <= base_d;
      nf_q            <= nf_d;
      sweep_q         <= sweep_d;
      lvl_q           <= lvl_d;
      t1_q            <= t1_d;
      t0_q            <= t0_d;
      op_q            <= op_d;
      vpn_q           <= vpn_d;
      ppn_q           <= ppn_d;
      flags_q         <= flags_d;
      free_q          <= free_d;
      rend_q          <= rend_d;
      res_status_q    <= res_status_d;
      res_rel_valid_q <= res_rel_valid_d;
      res_rel_page_q  <= res_rel_page_d;
      out_valid_q     <= out_valid_d;
      out_status_q    <= out_status_d;
      out_rel_valid_q <= out_rel_valid_d;
      out_rel_page_q  <= out_rel_page_d;
      out_last_q      <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_rel_page_q);
  assign m_axis_tuser  = {out_rel_valid_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/sv39ptm_checker.sv */
module sv39ptm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sv39ptm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [sv39ptm_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                              m_axis_tlast
);

  import sv39ptm_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Requests are handled one at a time, so ready drops right after an acceptance.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // Only an unmap that cleared a leaf can release a frame.
  a_release_on_unmap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[STATUS_W] |->
      m_axis_tuser[STATUS_W-1:0] == ST_UNMAPPED)
    else $error("release reported without an unmapped leaf");

  // Without a cleared leaf the released page reads as zero.
  a_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[STATUS_W-1:0] != ST_UNMAPPED) |->
      m_axis_tdata == '0)
    else $error("released page nonzero without an unmapped leaf");

endmodule

bind sv39_page_table_mapper sv39ptm_checker u_sv39ptm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sv39ptm_pkg::*;

  // The slowest correct run is the clearing after reset, 63 table allocations and some
  // 1400 requests with gaps and stalls. The limit is several times that.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DIRECTED_ROWS = 24;

  typedef struct packed {
    op_e               op;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
    logic [FLAG_W-1:0] flags;
    logic              release_req;
    logic              range_end;
  } page_request_t;

  typedef struct packed {
    status_e           status;
    logic              release_valid;
    logic [PPN_W-1:0]  released_page;
    logic              range_done;
  } page_result_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_POOL_BASE
  } row_kind_e;

  // One line of the directed table. On a register row the ppn column carries the new
  // pool base. Where typed is set, the expected result is the one written in the row.
  typedef struct packed {
    row_kind_e         kind;
    op_e               op;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
    logic [FLAG_W-1:0] flags;
    logic              release_req;
    logic              range_end;
    logic              typed;
    status_e           status;
    logic              release_valid;
    logic [PPN_W-1:0]  released_page;
  } step_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [PPN_W-1:0]     cfg_wr_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  sv39_page_table_mapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mirror of the block's page tables, bump allocator and pool base.
  logic [ENTRY_W-1:0] walk_tables [MEM_DEPTH];
  int unsigned        next_table;
  logic [PPN_W-1:0]   pool_base;

  page_result_t outcome_queue [$];
  int unsigned  failures;
  int unsigned  requests_sent;
  int unsigned  status_seen [4];
  int unsigned  base_settings;

  // Both sides idle at random unless quiet is set; hold_results asks the result side
  // for one long stall.
  bit quiet;
  bit hold_results;

  // Working set of table indices, so that most random requests land on tables and
  // leaves that already exist.
  logic [IDX_W-1:0] hot_top  [3];
  logic [IDX_W-1:0] hot_mid  [4];
  logic [IDX_W-1:0] hot_leaf [16];

  step_row_t directed_steps [DIRECTED_ROWS] = '{
    // Register written once at its reset value.
    '{ROW_POOL_BASE, OP_MAP,   27'h0000000, 44'h0, 10'h000, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    // Nothing is mapped after reset.
    '{ROW_REQUEST,   OP_UNMAP, 27'h0000000, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b1, ST_NOTHING, 1'b0, 44'h0},
    // First map allocates two tables.
    '{ROW_REQUEST,   OP_MAP,   27'h0000000, 44'h0, 10'h000, 1'b0, 1'b0,
      1'b1, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h0000000, 44'h0, 10'h000, 1'b1, 1'b1,
      1'b1, ST_UNMAPPED, 1'b1, 44'h0},
    // All-ones page, frame and flags; the release request is ignored on a map.
    '{ROW_REQUEST,   OP_MAP,   27'h7FFFFFF, 44'hFFFFFFFFFFF, 10'h3FF, 1'b1, 1'b1,
      1'b1, ST_MAPPED, 1'b0, 44'h0},
    // Unmap without a release request still names the frame.
    '{ROW_REQUEST,   OP_UNMAP, 27'h7FFFFFF, 44'h0, 10'h000, 1'b0, 1'b0,
      1'b1, ST_UNMAPPED, 1'b0, 44'hFFFFFFFFFFF},
    '{ROW_REQUEST,   OP_MAP,   27'h7FFFFFF, 44'h123456789AB, 10'h2AA, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    // Map over a valid leaf overwrites it.
    '{ROW_REQUEST,   OP_MAP,   27'h7FFFFFF, 44'hABCDEF01234, 10'h155, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h7FFFFFF, 44'h0, 10'h000, 1'b1, 1'b1,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h7FFFFFF, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b1, ST_NOTHING, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_MAP,   27'h00001FF, 44'h55555555555, 10'h000, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_MAP,   27'h0000200, 44'hAAAAAAAAAAA, 10'h3FE, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    // Middle-level entry never written.
    '{ROW_REQUEST,   OP_UNMAP, 27'h003FFFF, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b1, ST_NOTHING, 1'b0, 44'h0},
    // Root entry never written.
    '{ROW_REQUEST,   OP_UNMAP, 27'h4000000, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b1, ST_NOTHING, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_MAP,   27'h0000201, 44'h00000000001, 10'h001, 1'b0, 1'b1,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h0000200, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    // Moving the pool leaves the existing root links pointing outside it.
    '{ROW_POOL_BASE, OP_MAP,   27'h0000000, 44'h000000003E8, 10'h000, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_MAP,   27'h00001FF, 44'h00000000007, 10'h000, 1'b0, 1'b0,
      1'b1, ST_EXHAUSTED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h00001FF, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b1, ST_NOTHING, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_MAP,   27'h4000000, 44'h00000000ABC, 10'h0F0, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h4000000, 44'h0, 10'h000, 1'b0, 1'b1,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    // Back at base zero the old tables are reachable again, the new ones are not.
    '{ROW_POOL_BASE, OP_MAP,   27'h0000000, 44'h0, 10'h000, 1'b0, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h00001FF, 44'h0, 10'h000, 1'b1, 1'b0,
      1'b0, ST_MAPPED, 1'b0, 44'h0},
    '{ROW_REQUEST,   OP_UNMAP, 27'h4000000, 44'h0, 10'h000, 1'b1, 1'b1,
      1'b0, ST_MAPPED, 1'b0, 44'h0}
  };

  // ---------------------------------------------------------------------------------
  // Page table predictor.
  // ---------------------------------------------------------------------------------

  // Turns a valid upper entry into a table number; false when the entry names a page
  // outside the pool.
  function automatic bit resolve_link(input logic [ENTRY_W-1:0] entry,
                                      output int unsigned tab);
    logic [PPN_W-1:0] offset;
    offset = entry[ENTRY_W-1:FLAG_W] - pool_base;
    tab    = 32'(offset[TAB_W-1:0]);
    return offset < PPN_W'(TABLE_POOL);
  endfunction

  function automatic logic [ENTRY_W-1:0] link_entry(input int unsigned tab);
    return {pool_base + PPN_W'(tab), FLAG_W'(1)};
  endfunction

  function automatic int unsigned claim_table();
    int unsigned tab;
    tab = next_table;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) walk_tables[tab * TABLE_ENTRIES + i] = '0;
    next_table = tab + 1;
    return tab;
  endfunction

  function automatic status_e map_page(input logic [VPN_W-1:0] vpn,
                                       input logic [PPN_W-1:0] ppn,
                                       input logic [FLAG_W-1:0] flags);
    logic [ENTRY_W-1:0] top_entry;
    logic [ENTRY_W-1:0] mid_entry;
    int unsigned        mid_tab;
    int unsigned        leaf_tab;
    int unsigned        needed;
    mid_tab  = 0;
    leaf_tab = 0;
    top_entry = walk_tables[vpn[2*IDX_W +: IDX_W]];
    if (top_entry[0]) begin
      if (!resolve_link(top_entry, mid_tab)) return ST_EXHAUSTED;
      mid_entry = walk_tables[mid_tab * TABLE_ENTRIES + vpn[IDX_W +: IDX_W]];
      if (mid_entry[0]) begin
        if (!resolve_link(mid_entry, leaf_tab)) return ST_EXHAUSTED;
        needed = 0;
      end else begin
        needed = 1;
      end
    end else begin
      needed = 2;
    end
    // Both levels are checked against the free tables before anything is taken.
    if (next_table > TABLE_POOL || TABLE_POOL - next_table < needed) return ST_EXHAUSTED;
    if (needed == 2) begin
      mid_tab = claim_table();
      walk_tables[vpn[2*IDX_W +: IDX_W]] = link_entry(mid_tab);
    end
    if (needed >= 1) begin
      leaf_tab = claim_table();
      walk_tables[mid_tab * TABLE_ENTRIES + vpn[IDX_W +: IDX_W]] = link_entry(leaf_tab);
    end
    walk_tables[leaf_tab * TABLE_ENTRIES + vpn[0 +: IDX_W]] = {ppn, flags | FLAG_W'(1)};
    return ST_MAPPED;
  endfunction

  function automatic page_result_t unmap_page(input logic [VPN_W-1:0] vpn,
                                              input logic release_req);
    page_result_t       outcome;
    logic [ENTRY_W-1:0] entry;
    int unsigned        tab;
    int unsigned        leaf_slot;
    bit                 reachable;
    outcome        = '0;
    outcome.status = ST_NOTHING;
    tab            = 0;
    reachable      = 1'b0;
    entry = walk_tables[vpn[2*IDX_W +: IDX_W]];
    if (entry[0] && resolve_link(entry, tab)) begin
      entry = walk_tables[tab * TABLE_ENTRIES + vpn[IDX_W +: IDX_W]];
      if (entry[0] && resolve_link(entry, tab)) reachable = 1'b1;
    end
    if (reachable) begin
      leaf_slot = tab * TABLE_ENTRIES + vpn[0 +: IDX_W];
      entry     = walk_tables[leaf_slot];
      if (entry[0]) begin
        outcome.status        = ST_UNMAPPED;
        outcome.release_valid = release_req;
        outcome.released_page = entry[ENTRY_W-1:FLAG_W];
        walk_tables[leaf_slot] = '0;
      end
    end
    return outcome;
  endfunction

  function automatic page_result_t apply_page_op(input page_request_t rq);
    page_result_t outcome;
    if (rq.op == OP_MAP) begin
      outcome        = '0;
      outcome.status = map_page(rq.vpn, rq.ppn, rq.flags);
    end else begin
      outcome = unmap_page(rq.vpn, rq.release_req);
    end
    outcome.range_done = rq.range_end;
    return outcome;
  endfunction

  // Mostly requests on the working set with random content; the rest are scattered
  // pages, mostly unmaps so that the pool does not run dry in the first phase.
  function automatic page_request_t random_request();
    page_request_t rq;
    rq.ppn         = PPN_W'({$urandom(), $urandom()});
    rq.flags       = FLAG_W'($urandom());
    rq.release_req = 1'($urandom_range(0, 1));
    rq.range_end   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) < 90) begin
      rq.op  = ($urandom_range(0, 99) < 55) ? OP_MAP : OP_UNMAP;
      rq.vpn = {hot_top[$urandom_range(0, 2)], hot_mid[$urandom_range(0, 3)],
                hot_leaf[$urandom_range(0, 15)]};
    end else begin
      rq.op  = ($urandom_range(0, 99) < 30) ? OP_MAP : OP_UNMAP;
      rq.vpn = VPN_W'($urandom());
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------------

  // Offers one request, waits for it to be taken, then queues its expected result.
  task automatic push_request(input page_request_t rq, input bit typed,
                              input page_result_t written);
    page_result_t predicted;
    if (!quiet && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tlast  <= rq.range_end;
    s_axis_tdata  <= S_TDATA_W'({rq.release_req, rq.flags, rq.ppn, rq.vpn});
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_page_op(rq);
    outcome_queue.push_back(typed ? written : predicted);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (outcome_queue.size() != 0) @(posedge clk_i);
  endtask

  // The pool base only moves once every result is back, so the block is idle.
  task automatic write_pool_base(input logic [PPN_W-1:0] value);
    wait_drained();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    pool_base = value;
    base_settings++;
  endtask

  task automatic run_random_phase(input logic [PPN_W-1:0] base, input int unsigned count,
                                  input int unsigned quiet_items, input int unsigned hold_at);
    write_pool_base(base);
    for (int unsigned n = 0; n < count; n++) begin
      quiet = (n < quiet_items);
      if (hold_at != 0 && n == hold_at) hold_results = 1'b1;
      push_request(random_request(), 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------
  // Clock, result side, watchdog.
  // ---------------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: ready most cycles, always ready while quiet, and once a long stall so
  // that the block backs up and holds off new requests.
  initial begin : result_sink
    int unsigned held;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Each result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    page_result_t seen;
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.status        = status_e'(m_axis_tuser[STATUS_W-1:0]);
      seen.release_valid = m_axis_tuser[STATUS_W];
      seen.released_page = m_axis_tdata[PPN_W-1:0];
      seen.range_done    = m_axis_tlast;
      status_seen[seen.status]++;
      if (outcome_queue.size() == 0) begin
        $error("result with no request outstanding: status %s", seen.status.name());
        failures++;
      end else begin
        want = outcome_queue.pop_front();
        if (seen.status != want.status) begin
          $error("status: expected %s, got %s", want.status.name(), seen.status.name());
          failures++;
        end
        if (seen.release_valid != want.release_valid) begin
          $error("release_valid: expected %0d, got %0d", want.release_valid,
                 seen.release_valid);
          failures++;
        end
        if (seen.released_page != want.released_page) begin
          $error("released_page: expected 0x%0h, got 0x%0h", want.released_page,
                 seen.released_page);
          failures++;
        end
        if (seen.range_done != want.range_done) begin
          $error("range_done: expected %0d, got %0d", want.range_done, seen.range_done);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------

  initial begin : main_sequence
    page_request_t rq;
    page_result_t  written;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    quiet         = 1'b0;
    hold_results  = 1'b0;
    failures      = 0;
    requests_sent = 0;
    base_settings = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int unsigned i = 0; i < MEM_DEPTH; i++) walk_tables[i] = '0;
    next_table = 1;
    pool_base  = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The block clears its memory after reset; the first request simply
    // waits for s_axis_tready.
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_POOL_BASE) begin
        write_pool_base(directed_steps[i].ppn);
      end else begin
        rq.op                 = directed_steps[i].op;
        rq.vpn                = directed_steps[i].vpn;
        rq.ppn                = directed_steps[i].ppn;
        rq.flags              = directed_steps[i].flags;
        rq.release_req        = directed_steps[i].release_req;
        rq.range_end          = directed_steps[i].range_end;
        written.status        = directed_steps[i].status;
        written.release_valid = directed_steps[i].release_valid;
        written.released_page = directed_steps[i].released_page;
        written.range_done    = directed_steps[i].range_end;
        push_request(rq, directed_steps[i].typed, written);
      end
    end

    foreach (hot_top[i])  hot_top[i]  = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    foreach (hot_mid[i])  hot_mid[i]  = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    foreach (hot_leaf[i]) hot_leaf[i] = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));

    // Base zero with one long result stall; then the top base, which shifts every
    // existing link by one table, with a stretch of no idling; then a random base that
    // strands the old links; and base zero again over what is left. Each change waits
    // for the block to drain. The pool runs out along the way.
    run_random_phase('0, 450, 0, 120);
    run_random_phase('1, 350, 150, 0);
    run_random_phase(PPN_W'({$urandom(), $urandom()}), 300, 0, 0);
    run_random_phase('0, 300, 0, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d page requests over %0d pool base settings, %0d tables allocated",
             requests_sent, base_settings, next_table - 1);
    $display("summary: %0d mapped, %0d unmapped, %0d nothing mapped, %0d pool exhausted",
             status_seen[ST_MAPPED], status_seen[ST_UNMAPPED], status_seen[ST_NOTHING],
             status_seen[ST_EXHAUSTED]);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
